FILE: rtl/tkst_pkg.sv
package tkst_pkg;

	localparam int VALUE_W = 32;
	localparam int SUM_W   = 38;
	localparam int TOPK_W  = 7;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	typedef struct packed {
		logic [1:0]                op;
		logic signed [VALUE_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] top_sum;
		logic [1:0]              status;
	} rsp_t;

	typedef struct packed {
		logic                      ins;
		logic                      rem;
		logic signed [VALUE_W-1:0] value;
	} cell_cmd_t;

	typedef struct packed {
		logic ge;
		logic match;
	} cell_flag_t;

endpackage

FILE: rtl/tkst_cell.sv
module tkst_cell
	import tkst_pkg::*;
(
	input  logic                      clk,
	input  cell_cmd_t                 cmd,
	input  logic                      occupied,
	input  logic signed [VALUE_W-1:0] left_value,
	input  logic                      left_ge,
	input  logic signed [VALUE_W-1:0] right_value,
	output logic signed [VALUE_W-1:0] value,
	output cell_flag_t                flag
);

	logic signed [VALUE_W-1:0] value_q;
	logic                      gt;

	assign flag.ge    = occupied && (value_q >= cmd.value);
	assign flag.match = occupied && (value_q == cmd.value);
	assign gt         = occupied && (value_q > cmd.value);
	assign value      = value_q;

	// An insert pushes every smaller value one place down the row; a remove
	// pulls every value at or below the removed one up by one place.
	always_ff @(posedge clk) begin
		if (cmd.ins && !flag.ge) begin
			value_q <= left_ge ? cmd.value : left_value;
		end else if (cmd.rem && !gt) begin
			value_q <= right_value;
		end
	end

endmodule

FILE: rtl/top_k_sum_tracker_unit.sv
// Top-k sum tracker.
// Holds a multiset of signed 32-bit values in a row of cells sorted largest
// first, and the sum of the top_count largest of them.
// Request channel (req_valid, req_stall, req): each request is an insert, a
// remove of one instance, or a query. A request is taken when req_valid is
// high and req_stall is low.
// Response channel (rsp_valid, rsp_stall, rsp): one response per request,
// carrying the top-k sum after the step and a status code.
// Configuration channel (cfg_valid, cfg_ready, cfg_data): writing top_count
// empties the store and zeroes the sum. Write it only while no request is
// in flight.
// One request is worked on at a time: req_stall stays high from the cycle a
// request is taken until it executes, when the cell row shifts; the boundary
// values it shows are registered in the following cycle, before the next
// request can execute. A finished response waits in an output register; while
// it is stalled a further request may still be taken, but it is not
// executed until the waiting response has left.
// After reset the store is empty, top_count is zero and the sum is zero.
module top_k_sum_tracker_unit
	import tkst_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [TOPK_W-1:0] cfg_data,
	input  logic              req_valid,
	output logic              req_stall,
	input  req_t              req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output rsp_t              rsp
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > TOPK_W ? CNT_W : TOPK_W) + 1;

	logic                    busy_q;
	req_t                    req_q;
	logic [TOPK_W-1:0]       topk_q;
	logic [CNT_W-1:0]        cnt_q;
	logic signed [SUM_W-1:0] sum_q;
	logic                    rsp_valid_q;
	rsp_t                    rsp_q;
	logic signed [VALUE_W-1:0] bnd_a_q;
	logic signed [VALUE_W-1:0] bnd_b_q;

	cell_cmd_t               cmd;
	logic signed [VALUE_W-1:0] cell_value [CAPACITY];
	cell_flag_t              cell_flag [CAPACITY];
	logic [CAPACITY-1:0]     occupied;
	logic [CAPACITY-1:0]     sel_a;
	logic [CAPACITY-1:0]     sel_b;
	logic [CAPACITY-1:0]     match_vec;

	logic                    exec;
	logic                    is_ins;
	logic                    is_rem;
	logic                    full;
	logic                    found;
	logic [CMP_W-1:0]        k_ext;
	logic [CMP_W-1:0]        n_ext;
	logic signed [SUM_W-1:0] v_ext;
	logic signed [SUM_W-1:0] a_ext;
	logic signed [SUM_W-1:0] b_ext;
	logic                    ins_top;
	logic                    rem_top;
	logic signed [SUM_W-1:0] sum_next;
	logic [1:0]              status_next;
	logic signed [VALUE_W-1:0] bnd_a_next;
	logic signed [VALUE_W-1:0] bnd_b_next;

	assign req_stall = busy_q;
	assign cfg_ready = !busy_q;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign exec   = busy_q && (!rsp_valid_q || !rsp_stall);
	assign is_ins = (req_q.op == OP_INSERT);
	assign is_rem = (req_q.op == OP_REMOVE);
	assign full   = (cnt_q == CNT_W'(CAPACITY));
	assign found  = |match_vec;

	assign cmd.ins   = exec && is_ins && !full;
	assign cmd.rem   = exec && is_rem && found;
	assign cmd.value = req_q.value;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [VALUE_W-1:0] left_value;
		logic                      left_ge;
		logic signed [VALUE_W-1:0] right_value;

		assign occupied[i]  = (cnt_q > CNT_W'(i));
		assign sel_a[i]     = (k_ext == CMP_W'(i + 1));
		assign sel_b[i]     = (k_ext == CMP_W'(i));
		assign match_vec[i] = cell_flag[i].match;

		if (i == 0) begin : g_first
			assign left_value = req_q.value;
			assign left_ge    = 1'b1;
		end else begin : g_inner
			assign left_value = cell_value[i-1];
			assign left_ge    = cell_flag[i-1].ge;
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_value = '0;
		end else begin : g_body
			assign right_value = cell_value[i+1];
		end

		tkst_cell u_cell (
			.clk         (clk),
			.cmd         (cmd),
			.occupied    (occupied[i]),
			.left_value  (left_value),
			.left_ge     (left_ge),
			.right_value (right_value),
			.value       (cell_value[i]),
			.flag        (cell_flag[i])
		);
	end

	// Values at the top-k boundary: entry top_count-1 and entry top_count.
	always_comb begin
		bnd_a_next = '0;
		bnd_b_next = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			bnd_a_next = bnd_a_next | (cell_value[i] & {VALUE_W{sel_a[i]}});
			bnd_b_next = bnd_b_next | (cell_value[i] & {VALUE_W{sel_b[i]}});
		end
	end

	always_ff @(posedge clk) begin
		bnd_a_q <= bnd_a_next;
		bnd_b_q <= bnd_b_next;
	end

	assign k_ext = CMP_W'(topk_q);
	assign n_ext = CMP_W'(cnt_q);
	assign v_ext = SUM_W'(req_q.value);
	assign a_ext = SUM_W'(bnd_a_q);
	assign b_ext = SUM_W'(bnd_b_q);

	assign ins_top = (k_ext != '0) && ((n_ext < k_ext) || (bnd_a_q < req_q.value));
	assign rem_top = (k_ext != '0) && ((n_ext <= k_ext) || (bnd_a_q <= req_q.value));

	always_comb begin
		sum_next    = sum_q;
		status_next = ST_OK;
		if (is_ins) begin
			if (full) begin
				status_next = ST_FULL;
			end else if (ins_top) begin
				sum_next = sum_q + v_ext - ((n_ext >= k_ext) ? a_ext : SUM_W'(0));
			end
		end else if (is_rem) begin
			if (!found) begin
				status_next = ST_NOT_FOUND;
			end else if (rem_top) begin
				sum_next = sum_q - v_ext + ((n_ext > k_ext) ? b_ext : SUM_W'(0));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !busy_q) begin
			req_q <= req;
		end
		if (exec) begin
			rsp_q.top_sum <= sum_next;
			rsp_q.status  <= status_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			topk_q      <= '0;
			cnt_q       <= '0;
			sum_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req_valid && !busy_q) begin
				busy_q <= 1'b1;
			end else if (exec) begin
				busy_q <= 1'b0;
			end

			if (exec) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			if (cfg_valid && cfg_ready) begin
				topk_q <= cfg_data;
				cnt_q  <= '0;
				sum_q  <= '0;
			end else if (exec) begin
				sum_q <= sum_next;
				if (cmd.ins) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end else if (cmd.rem) begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
		end
	end

endmodule

FILE: rtl/tkst_checker.sv
module tkst_checker
	import tkst_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cfg_ready,
	input logic req_valid,
	input logic req_stall,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	// A stalled response holds its contents.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	// Only one request is in flight at a time.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall && !cfg_ready)
		else $error("second request taken while one is in flight");

	// A new response only comes from a request that was in flight.
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("response without a request in flight");

	// The status code is always one of the defined ones.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.status == ST_OK || rsp.status == ST_FULL ||
			rsp.status == ST_NOT_FOUND))
		else $error("undefined status code");

endmodule

bind top_k_sum_tracker_unit tkst_checker u_tkst_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_ready (cfg_ready),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
